FILE: src/kalman_angle_filter_defines.svh
// Assertion macros shared by the Kalman angle filter RTL.
// No dependencies; guarded against double inclusion.
`ifndef KALMAN_ANGLE_FILTER_DEFINES_SVH
`define KALMAN_ANGLE_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define KAF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KAF_ASSERT_ONEHOT(label, clk, rst_n, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) $onehot(sig)) else $error(msg);
`else
`define KAF_ASSERT(label, clk, rst_n, prop, msg)
`define KAF_ASSERT_ONEHOT(label, clk, rst_n, sig, msg)
`endif
`endif

FILE: src/kaf_pkg.sv
// Types and constants for the Kalman angle filter.
// No dependencies.
package kaf_pkg;
	localparam int COV_FRAC = 30;
	localparam int CFG_W    = 31;
	localparam logic [1:0] REG_DT = 2'd0;
	localparam logic [1:0] REG_QA = 2'd1;
	localparam logic [1:0] REG_QB = 2'd2;
	localparam logic [1:0] REG_R  = 2'd3;
	localparam logic [30:0] RST_DT = 31'd10737418;
	localparam logic [30:0] RST_QA = 31'd1073742;
	localparam logic [30:0] RST_QB = 31'd3221225;
	localparam logic [30:0] RST_R  = 31'd32212255;

	typedef enum logic [1:0] {
		OP_MUL = 2'b01,
		OP_DIV = 2'b10
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} ctl_t;
endpackage

FILE: src/kaf_serial_unit.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// Depends on kaf_pkg. mul: floor(a*b/2^30); div: floor(a*2^30/b), b>0; saturated to W bits.
`include "kalman_angle_filter_defines.svh"
module kaf_serial_unit #(
	parameter int W  = 32,
	parameter int AW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kaf_pkg::ctl_t        ctl,
	input  logic signed [AW-1:0] a,
	input  logic signed [AW-1:0] b,
	output logic                 done,
	output logic signed [W-1:0]  res
);
	import kaf_pkg::*;
	localparam int PW = 2*AW + COV_FRAC + 2;
	localparam int CW = $clog2(PW + 1);
	localparam int QW = AW + COV_FRAC + 1;
	localparam logic [PW-1:0] LIMP = PW'({1'b0, {(W-1){1'b1}}});

	logic          busy_q, isdiv_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] acc_q;   // product, or remainder for division
	logic [AW-1:0] mc_q;    // multiplier bits / divisor
	logic [QW-1:0] num_q;   // multiplicand / dividend shift
	logic [PW-1:0] lim;
	logic [PW-1:0] mag_out;
	logic [PW-1:0] rtry;
	logic [PW-1:0] frac_mask;
	logic          rnz;
	logic [AW-1:0] ma, mb;

	always_comb begin
		ma = a[AW-1] ? AW'(-a) : AW'(a);
		mb = b[AW-1] ? AW'(-b) : AW'(b);
		lim = LIMP + PW'(neg_q);
		rtry = {acc_q[PW-2:0], num_q[QW-1]};
		frac_mask = (PW'(1) << COV_FRAC) - PW'(1);
		if (isdiv_q) begin
			rnz = acc_q != '0;
			mag_out = PW'(num_q) + PW'(neg_q && rnz);
		end else begin
			rnz = (acc_q & frac_mask) != '0;
			mag_out = (acc_q >> COV_FRAC) + PW'(neg_q && rnz);
		end
		if (mag_out > lim) mag_out = lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ctl.op == OP_DIV ? QW : AW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			isdiv_q <= (ctl.op == OP_DIV);
			acc_q   <= '0;
			if (ctl.op == OP_DIV) begin
				neg_q <= a[AW-1];
				num_q <= {1'b0, ma, {COV_FRAC{1'b0}}};
				mc_q  <= AW'(b);
			end else begin
				neg_q <= a[AW-1] ^ b[AW-1];
				num_q <= QW'(ma);
				mc_q  <= mb;
			end
		end else if (busy_q) begin
			if (isdiv_q) begin
				if (rtry >= PW'(mc_q)) begin
					acc_q <= rtry - PW'(mc_q);
					num_q <= {num_q[QW-2:0], 1'b1};
				end else begin
					acc_q <= rtry;
					num_q <= {num_q[QW-2:0], 1'b0};
				end
			end else begin
				// MSB-first shift-add
				acc_q <= (acc_q << 1) + (mc_q[AW-1] ? PW'(num_q) : '0);
				mc_q  <= {mc_q[AW-2:0], 1'b0};
			end
		end
		if (done) res <= neg_q ? W'(-mag_out) : W'(mag_out);
	end

	// The result register loads in the cycle after done; caller samples later.
	`KAF_ASSERT(a_no_start_busy, clk, arst_n, ctl.start |-> !busy_q, "start while busy")
	`KAF_ASSERT(a_done_end, clk, arst_n, done |-> $past(busy_q), "done without work")
	`KAF_ASSERT(a_done_pulse, clk, arst_n, done |=> !done, "done held")
endmodule

FILE: src/kalman_angle_filter.sv
// Top level of the one-axis Kalman angle/bias filter.
// Depends on kaf_pkg and kaf_serial_unit.
//
// Usage: the input channel (in_valid/in_stall) carries tilt_meas, turn_rate
// and restart; the output channel (out_valid/out_stall) returns angle_estimate.
// One result per request. Each request runs a fixed sequence of 10 multiplies
// and 2 divides on one shared bit-serial unit. Each operation is issued, runs
// one bit step per multiplier or quotient bit, raises done and is then applied.
// The input is stalled for the whole computation, so a new request is taken
// only after the previous result has been loaded into the output. A held result
// waiting on out_stall does not block the following request; only a second
// finished result waits in the output step until the first has left.
// Reset: registers return to their defaults, angle and bias to zero, the
// covariance to identity. restart=1 resets angle, bias and covariance first.
// Configuration (APB, byte addresses 0,4,8,12) must be written while idle; not enforced.
`include "kalman_angle_filter_defines.svh"
module kalman_angle_filter #(
	parameter int WORD_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [24:0] tilt_meas,
	input  logic signed [27:0] turn_rate,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] angle_estimate
);
	import kaf_pkg::*;
	localparam int W = WORD_WIDTH;
	// operand width: registers are 31-bit unsigned and enter the unit unsaturated
	localparam int AW = (W > 32) ? W : 32;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE =
		(W > COV_FRAC + 1) ? W'(64'sd1 <<< COV_FRAC) : WMAX;

	// Sequencer steps; each working step issues one serial operation then applies it.
	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_ANG  = 14'b00000000000010,  // mulq(rate-bias, dt)
		ST_D    = 14'b00000000000100,  // d = mulq(dt, P11)
		ST_P00  = 14'b00000000001000,  // mulq(dt, t)
		ST_P11  = 14'b00000000010000,  // mulq(Qb, dt)
		ST_K0   = 14'b00000000100000,
		ST_K1   = 14'b00000001000000,
		ST_CA   = 14'b00000010000000,  // mulq(k0, y)
		ST_CB   = 14'b00000100000000,  // mulq(k1, y)
		ST_C00  = 14'b00001000000000,
		ST_C01  = 14'b00010000000000,
		ST_C10  = 14'b00100000000000,
		ST_C11  = 14'b01000000000000,
		ST_OUT  = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic   wait_q;  // operation issued, awaiting done
	logic   res_q;   // done seen, result registered and ready to apply

	logic [30:0] dt_q, qa_q, qb_q, r_q;
	logic signed [W-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [W-1:0] accel_q, rate_q, d_q, k0_q, k1_q, y_q, p00t_q, p01t_q;
	logic signed [AW-1:0] opa, opb;
	logic signed [W-1:0] ures;
	logic                udone;
	ctl_t                uctl;
	logic                cfg_wr;
	logic                out_load;

	function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
			input logic signed [W-1:0] y);
		logic signed [W:0] s;
		s = {x[W-1], x} + {y[W-1], y};
		if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] x,
			input logic signed [W-1:0] y);
		logic signed [W:0] s;
		s = {x[W-1], x} - {y[W-1], y};
		if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
		return s[W-1:0];
	endfunction

	// word plus an unsaturated register value, saturated to the word
	function automatic logic signed [W-1:0] saddc(input logic signed [W-1:0] x,
			input logic [30:0] v);
		logic signed [AW:0] s;
		s = (AW+1)'(x) + $signed({{(AW-30){1'b0}}, v});
		if (s > (AW+1)'(WMAX)) return WMAX;
		if (s < (AW+1)'(WMIN)) return WMIN;
		return W'(s);
	endfunction

	function automatic logic signed [AW-1:0] cfgw(input logic [30:0] v);
		return {{(AW-31){1'b0}}, v};
	endfunction

	function automatic logic signed [W-1:0] satin(input logic signed [27:0] v);
		logic signed [47:0] z;
		z = 48'(v);
		if (z > 48'(WMAX)) return WMAX;
		if (z < 48'(WMIN)) return WMIN;
		return W'(z);
	endfunction

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	always_comb begin
		case (paddr[3:2])
			REG_DT:  prdata = {1'b0, dt_q};
			REG_QA:  prdata = {1'b0, qa_q};
			REG_QB:  prdata = {1'b0, qb_q};
			REG_R:   prdata = {1'b0, r_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= RST_DT;
			qa_q <= RST_QA;
			qb_q <= RST_QB;
			r_q  <= RST_R;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DT:  dt_q <= pwdata[30:0];
				REG_QA:  qa_q <= pwdata[30:0];
				REG_QB:  qb_q <= pwdata[30:0];
				REG_R:   r_q  <= pwdata[30:0];
				default: dt_q <= dt_q;
			endcase
		end
	end

	// Operand select for the step being issued.
	always_comb begin
		opa = '0;
		opb = '0;
		uctl.op = OP_MUL;
		case (state_q)
			ST_ANG:  begin opa = AW'(ssub(rate_q, bias_q)); opb = cfgw(dt_q); end
			ST_D:    begin opa = cfgw(dt_q); opb = AW'(p11_q); end
			ST_P00:  begin
				opa = cfgw(dt_q);
				opb = AW'(saddc(ssub(ssub(d_q, p01_q), p10_q), qa_q));
			end
			ST_P11:  begin opa = cfgw(qb_q); opb = cfgw(dt_q); end
			ST_K0:   begin
				opa = AW'(p00_q); opb = AW'(saddc(p00_q, r_q)); uctl.op = OP_DIV;
			end
			ST_K1:   begin
				opa = AW'(p10_q); opb = AW'(saddc(p00_q, r_q)); uctl.op = OP_DIV;
			end
			ST_CA:   begin opa = AW'(k0_q); opb = AW'(y_q); end
			ST_CB:   begin opa = AW'(k1_q); opb = AW'(y_q); end
			ST_C00:  begin opa = AW'(k0_q); opb = AW'(p00t_q); end
			ST_C01:  begin opa = AW'(k0_q); opb = AW'(p01t_q); end
			ST_C10:  begin opa = AW'(k1_q); opb = AW'(p00t_q); end
			ST_C11:  begin opa = AW'(k1_q); opb = AW'(p01t_q); end
			default: begin opa = '0; opb = '0; end
		endcase
		uctl.start = !wait_q && !res_q && state_q != ST_IDLE && state_q != ST_OUT;
	end

	kaf_serial_unit #(.W(W), .AW(AW)) u_serial (
		.clk(clk), .arst_n(arst_n), .ctl(uctl), .a(opa), .b(opb),
		.done(udone), .res(ures)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wait_q    <= 1'b0;
			res_q     <= 1'b0;
			out_valid <= 1'b0;
			ang_q  <= '0;
			bias_q <= '0;
			p00_q  <= ONE;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= ONE;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (uctl.start) wait_q <= 1'b1;
			if (udone) begin
				wait_q <= 1'b0;
				res_q  <= 1'b1;
			end
			case (state_q)
				ST_IDLE: if (in_valid && !in_stall) begin
					accel_q <= satin(28'(tilt_meas));
					rate_q  <= satin(turn_rate);
					if (restart) begin
						ang_q  <= '0;
						bias_q <= '0;
						p00_q  <= ONE;
						p01_q  <= '0;
						p10_q  <= '0;
						p11_q  <= ONE;
					end
					state_q <= ST_ANG;
				end
				ST_OUT: begin
					// hold until the previous result has left
					if (out_load) begin
						if (64'(ang_q) > 64'sd2147483647)
							angle_estimate <= 32'h7FFF_FFFF;
						else if (64'(ang_q) < -64'sd2147483648)
							angle_estimate <= 32'h8000_0000;
						else
							angle_estimate <= 32'(ang_q);
						state_q <= ST_IDLE;
					end
				end
				default: if (res_q) begin
					res_q <= 1'b0;
					case (state_q)
						ST_ANG: begin ang_q <= sadd(ang_q, ures); state_q <= ST_D; end
						ST_D: begin d_q <= ures; state_q <= ST_P00; end
						ST_P00: begin
							p00_q <= sadd(p00_q, ures);
							p01_q <= ssub(p01_q, d_q);
							p10_q <= ssub(p10_q, d_q);
							state_q <= ST_P11;
						end
						ST_P11: begin
							p11_q <= sadd(p11_q, ures);
							y_q <= ssub(accel_q, ang_q);
							state_q <= ST_K0;
						end
						ST_K0: begin
							k0_q <= (saddc(p00_q, r_q) > 0) ? ures : '0;
							state_q <= ST_K1;
						end
						ST_K1: begin
							k1_q <= (saddc(p00_q, r_q) > 0) ? ures : '0;
							p00t_q <= p00_q;
							p01t_q <= p01_q;
							state_q <= ST_CA;
						end
						ST_CA: begin ang_q <= sadd(ang_q, ures); state_q <= ST_CB; end
						ST_CB: begin bias_q <= sadd(bias_q, ures); state_q <= ST_C00; end
						ST_C00: begin p00_q <= ssub(p00_q, ures); state_q <= ST_C01; end
						ST_C01: begin p01_q <= ssub(p01_q, ures); state_q <= ST_C10; end
						ST_C10: begin p10_q <= ssub(p10_q, ures); state_q <= ST_C11; end
						ST_C11: begin p11_q <= ssub(p11_q, ures); state_q <= ST_OUT; end
						default: state_q <= ST_IDLE;
					endcase
				end
			endcase
		end
	end

	`KAF_ASSERT_ONEHOT(a_state_onehot, clk, arst_n, state_q, "state not one-hot")
	`KAF_ASSERT(a_idle_quiet, clk, arst_n, (state_q == ST_IDLE) |-> !wait_q && !res_q, "idle busy")
	`KAF_ASSERT(a_accept_start, clk, arst_n, (in_valid && !in_stall) |=> state_q == ST_ANG, "no start")
	`KAF_ASSERT(a_done_waits, clk, arst_n, udone |-> wait_q, "stray done")
endmodule

FILE: dv/testbench.sv
// Self-checking testbench for kalman_angle_filter: one-axis angle/bias fusion.
// Depends on kaf_pkg and the filter RTL; predicts every angle estimate itself.
`timescale 1ns / 100ps
module testbench;
	import kaf_pkg::*;

	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  SETTLE      = 700;
	localparam longint WMAX     = 64'sd2147483647;
	localparam longint WMIN     = -64'sd2147483648;
	localparam longint ONE_Q30  = 64'sd1 <<< COV_FRAC;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [24:0] tilt_meas = '0;
	logic signed [27:0] turn_rate = '0;
	logic               restart = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] angle_estimate;

	kalman_angle_filter dut (.*);

	always #2 clk = ~clk;

	// Filter mirror: registers and state as the block should hold them.
	logic [30:0] dt_q, qa_q, qb_q, r_q;
	longint angle_m, bias_m, p00, p01, p10, p11;

	logic signed [31:0] angle_queue[$];
	int mismatches = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int cycles = 0;
	bit quiet = 0;     // no idling on either side while set

	function automatic longint clamp_word(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	// Q2.30 product, floored
	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b;
		return clamp_word(p >>> COV_FRAC);
	endfunction

	// Q2.30 quotient, floored, den > 0
	function automatic longint qdiv(longint num, longint den);
		longint x, q;
		x = num <<< COV_FRAC;
		if (x >= 0) q = x / den;
		else q = -((-x + den - 1) / den);
		return clamp_word(q);
	endfunction

	function automatic void clear_state();
		angle_m = 0;
		bias_m = 0;
		p00 = ONE_Q30;
		p01 = 0;
		p10 = 0;
		p11 = ONE_Q30;
	endfunction

	// Advance the mirror by one sample and return the expected angle.
	function automatic logic signed [31:0] fuse_sample(logic signed [24:0] acc,
			logic signed [27:0] rate, logic rst);
		longint dt, d, t, s, k0, k1, y, p00t, p01t;
		dt = longint'(dt_q);
		k0 = 0;
		k1 = 0;
		if (rst) clear_state();
		angle_m = clamp_word(angle_m + qmul(clamp_word(longint'(rate) - bias_m), dt));
		d = qmul(dt, p11);
		t = clamp_word(clamp_word(clamp_word(d - p01) - p10) + longint'(qa_q));
		p00 = clamp_word(p00 + qmul(dt, t));
		p01 = clamp_word(p01 - d);
		p10 = clamp_word(p10 - d);
		p11 = clamp_word(p11 + qmul(longint'(qb_q), dt));
		s = clamp_word(p00 + longint'(r_q));
		if (s > 0) begin
			k0 = qdiv(p00, s);
			k1 = qdiv(p10, s);
		end
		y = clamp_word(longint'(acc) - angle_m);
		angle_m = clamp_word(angle_m + qmul(k0, y));
		bias_m = clamp_word(bias_m + qmul(k1, y));
		p00t = p00;
		p01t = p01;
		p00 = clamp_word(p00 - qmul(k0, p00t));
		p01 = clamp_word(p01 - qmul(k0, p01t));
		p10 = clamp_word(p10 - qmul(k1, p00t));
		p11 = clamp_word(p11 - qmul(k1, p01t));
		return angle_m[31:0];
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DT:  dt_q = value[30:0];
			REG_QA:  qa_q = value[30:0];
			REG_QB:  qb_q = value[30:0];
			REG_R:   r_q  = value[30:0];
			default: ;
		endcase
	endtask

	task automatic set_noise(logic [31:0] dt, logic [31:0] qa, logic [31:0] qb,
			logic [31:0] r);
		write_reg(REG_DT, dt);
		write_reg(REG_QA, qa);
		write_reg(REG_QB, qb);
		write_reg(REG_R, r);
	endtask

	// Send one request; on acceptance fold it into the mirror.
	task automatic send_sample(logic signed [24:0] acc, logic signed [27:0] rate,
			logic rst);
		int gap;
		gap = (!quiet && $urandom_range(99) < 30) ? $urandom_range(3, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		tilt_meas <= acc;
		turn_rate <= rate;
		restart <= rst;
		do @(posedge clk); while (in_stall);
		angle_queue.push_back(fuse_sample(acc, rate, rst));
		requests_sent++;
	endtask

	// Drop valid and wait out every pending result before touching registers.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (angle_queue.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Result checker and receiver stall.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (angle_queue.size() == 0) begin
				report_mismatch("unexpected angle_estimate", angle_estimate, 0);
			end else begin
				if (angle_estimate !== angle_queue[0])
					report_mismatch("angle_estimate", angle_estimate, angle_queue[0]);
				void'(angle_queue.pop_front());
			end
		end
		out_stall <= !quiet && ($urandom_range(99) < 30);
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic signed [24:0] pick_accel();
		if ($urandom_range(9) == 0) return 25'($urandom);
		return 25'($signed($urandom_range(23592960)) - 11796480);
	endfunction

	function automatic logic signed [27:0] pick_rate();
		if ($urandom_range(9) == 0) return 28'($urandom);
		return 28'($signed($urandom_range(262144000)) - 131072000);
	endfunction

	// Field extremes, restart, default registers.
	task automatic test_field_extremes();
		send_sample(25'sd11796480, 28'sd0, 1'b0);
		send_sample(-25'sd11796480, 28'sd131072000, 1'b0);
		send_sample(25'sd0, -28'sd131072000, 1'b0);
		send_sample(25'h0FFFFFF, 28'h7FFFFFF, 1'b0);
		send_sample(25'h1000000, 28'h8000000, 1'b0);
		send_sample(25'h1FFFFFF, 28'h0000001, 1'b1);
		send_sample(25'sd65536, 28'sd0, 1'b1);
		send_sample(25'sd65536, 28'sd65536, 1'b0);
		drain();
	endtask

	// Zero measurement noise, maximal dt and noises, top bit of a write dropped.
	task automatic test_register_extremes();
		set_noise(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'd0);
		send_sample(25'sd11796480, 28'sd131072000, 1'b1);
		send_sample(-25'sd11796480, -28'sd131072000, 1'b0);
		send_sample(25'h0FFFFFF, 28'h7FFFFFF, 1'b0);
		drain();
		set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(25'h1000000, 28'h8000000, 1'b0);
		send_sample(25'sd1000, 28'sd5000, 1'b0);
		send_sample(25'sd0, 28'sd0, 1'b1);
		drain();
		set_noise(32'd0, 32'd0, 32'd0, 32'd1);
		send_sample(25'sd655360, 28'sd655360, 1'b1);
		send_sample(-25'sd655360, 28'sd0, 1'b0);
		drain();
	endtask

	// Random phases: tracking sequences with noise, under several register sets.
	task automatic test_random_phases();
		int phase, n;
		logic signed [24:0] acc;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_noise(32'(RST_DT), 32'(RST_QA), 32'(RST_QB), 32'(RST_R));
				1: set_noise(32'h4000_0000, 32'd1, 32'd1, 32'h4000_0000);
				2: set_noise(32'd1, 32'h4000_0000, 32'h4000_0000, 32'd1);
				default: set_noise($urandom, $urandom, $urandom, $urandom);
			endcase
			quiet = (phase == 3);
			acc = pick_accel();
			for (n = 0; n < 100; n++) begin
				// mostly a slowly moving angle, sometimes a jump or restart
				if ($urandom_range(9) == 0) acc = pick_accel();
				else acc = acc + 25'($signed($urandom_range(131072)) - 65536);
				send_sample(acc, pick_rate(), $urandom_range(19) == 0);
			end
			quiet = 0;
			drain();
		end
	endtask

	initial begin
		dt_q = RST_DT;
		qa_q = RST_QA;
		qb_q = RST_QB;
		r_q = RST_R;
		clear_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_field_extremes();
		test_register_extremes();
		test_random_phases();
		$display("covered %0d requests, %0d results, register extremes and restarts",
			requests_sent, results_seen);
		if (mismatches == 0 && angle_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				angle_queue.size());
			$display("simulation failed");
		end
		$finish;
	end
endmodule
